// File: design/mmas_pkg.sv
// ----------------------------------------------------------------------------
// Moving-average scaler package
// Shared widths, constants and types for the six-channel boxcar scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package mmas_pkg;

    localparam int CHANNELS    = 6;
    localparam int SCALED_CH   = 5;
    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 16;
    localparam int GAIN_W      = 32;
    localparam int WINDOW_DEF  = 8;

    localparam logic [GAIN_W-1:0]  GAIN_RESET = 32'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'hFFFF;

    // Stream word widths, padded to whole bytes.
    localparam int IN_BITS     = CHANNELS * SAMPLE_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = SCALED_CH * LEVEL_W + SAMPLE_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Scaling: level = min(LEVEL_MAX, floor(avg * gain / 1000)).
    localparam longint unsigned MILLI     = 64'd1000;
    localparam int              PROD_W    = SAMPLE_W + GAIN_W;
    // Products at or above this value saturate.
    localparam longint unsigned SAT_LIMIT = (64'(LEVEL_MAX) + 64'd1) * MILLI;
    // Below SAT_LIMIT the product fits DIV_N bits; divide by 1000 through an
    // exact reciprocal ceil(2^(DIV_N+DIV_L) / 1000).
    localparam int              DIV_N     = $clog2(SAT_LIMIT);
    localparam int              DIV_L     = $clog2(MILLI);
    localparam int              DIV_SHIFT = DIV_N + DIV_L;
    localparam longint unsigned MILLI_RECIP =
        ((64'd1 << DIV_SHIFT) + MILLI - 64'd1) / MILLI;
    localparam int              RECIP_W   = $clog2(MILLI_RECIP + 64'd1);
    localparam int              QP_W      = DIV_N + RECIP_W;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] t_sample_vec;

    typedef struct packed {
        logic load;     // new word enters the ring stage
        logic advance;  // ring stage word commits to memory and sums
    } t_win_ctrl;

endpackage

`default_nettype wire

// File: design/mmas_window.sv
// ----------------------------------------------------------------------------
// Moving-average window ring
// Per-row sample ring with valid bits, write pointer and running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module mmas_window #(
    parameter  int WINDOW = mmas_pkg::WINDOW_DEF,
    localparam int SUM_W  = $clog2(((1 << mmas_pkg::SAMPLE_W) - 1) * WINDOW + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  mmas_pkg::t_win_ctrl      i_ctrl,
    input  mmas_pkg::t_sample_vec    i_samples,
    output logic [mmas_pkg::CHANNELS-1:0][SUM_W-1:0] o_sums
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW - 1);

    mmas_pkg::t_sample_vec r_mem [WINDOW];
    logic [WINDOW-1:0]     r_row_vld;
    logic [PTR_W-1:0]      r_wpos;
    logic [PTR_W-1:0]      r_rd_pos;
    mmas_pkg::t_sample_vec r_samp;
    mmas_pkg::t_sample_vec r_old;
    logic [mmas_pkg::CHANNELS-1:0][SUM_W-1:0] r_sum;
    logic [mmas_pkg::CHANNELS-1:0][SUM_W-1:0] n_sum;
    logic                  bypass;

    // Word leaving the ring stage writes the slot the new word reads.
    assign bypass = i_ctrl.advance && (r_rd_pos == r_wpos);

    always_comb begin
        for (int ch = 0; ch < mmas_pkg::CHANNELS; ch++) begin
            n_sum[ch] = r_sum[ch] - SUM_W'(r_old[ch]) + SUM_W'(r_samp[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_row_vld <= '0;
            r_sum     <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_wpos <= (r_wpos == LAST_POS) ? '0 : r_wpos + PTR_W'(1);
            end
            if (i_ctrl.advance) begin
                r_row_vld[r_rd_pos] <= 1'b1;
                r_sum               <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_samp   <= i_samples;
            r_rd_pos <= r_wpos;
            if (bypass) begin
                r_old <= r_samp;
            end else if (r_row_vld[r_wpos]) begin
                r_old <= r_mem[r_wpos];
            end else begin
                r_old <= '0;
            end
        end
        if (i_ctrl.advance) begin
            r_mem[r_rd_pos] <= r_samp;
        end
    end

    assign o_sums = r_sum;

endmodule

`default_nettype wire

// File: design/multichannel_moving_average_scaler.sv
// ----------------------------------------------------------------------------
// Six-channel moving-average scaler
// Boxcar average over WINDOW words per channel, gain scaling in thousandths on the first five.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless m_axis_tready stalls; the ring memory
// (one read, one write port per cycle) and the running-sum update set this, with a bypass for WINDOW=1.
// Reset (synchronous, i_rst_n low): clear pipeline valids, ring row valid
// bits, running sums and write pointer; load gain_milli with 1000. Ring rows
// never written read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_moving_average_scaler #(
    parameter int WINDOW = mmas_pkg::WINDOW_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration: gain_milli write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [mmas_pkg::GAIN_W-1:0]         i_cfg_data,
    // Sample words in
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: ntc1_sample, ntc2_sample, rail12_sample,
    // core1_sample, core2_sample, base_sample, zero fill
    input  wire  [mmas_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Level words out
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // tdata, low bit up: ntc1_level, ntc2_level, rail12_level,
    // core1_level, core2_level, base average (unscaled), zero fill
    output logic [mmas_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int CH    = mmas_pkg::CHANNELS;
    localparam int SCH   = mmas_pkg::SCALED_CH;
    localparam int SW    = mmas_pkg::SAMPLE_W;
    localparam int LW    = mmas_pkg::LEVEL_W;
    localparam int SUM_W = $clog2(((1 << SW) - 1) * WINDOW + 1);

    // floor(sum / WINDOW) == (sum * AVG_M) >> (SUM_W + AVG_L) for every sum
    // that fits SUM_W bits, with AVG_M = ceil(2^(SUM_W+AVG_L) / WINDOW).
    localparam int AVG_L = $clog2(WINDOW);
    localparam int AVG_S = SUM_W + AVG_L;
    localparam longint unsigned AVG_M =
        ((64'd1 << AVG_S) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int AM_W  = SUM_W + 2;
    localparam int AP_W  = SUM_W + AM_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [mmas_pkg::GAIN_W-1:0] r_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= mmas_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   stage 1: ring read   stage 2: running sums   stage 3: averages
    //   stage 4: gain products   stage 5: output register
    // Each stage takes a word when empty or when its word moves on.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic in_accept;

    assign rdy5 = !r_v5 || m_axis_tready;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign s_axis_tready = rdy1;
    assign in_accept     = s_axis_tvalid && rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2: sample ring and running sums
    // ------------------------------------------------------------------
    mmas_pkg::t_win_ctrl   win_ctrl;
    mmas_pkg::t_sample_vec in_samples;
    logic [CH-1:0][SUM_W-1:0] sums;

    assign in_samples = s_axis_tdata[mmas_pkg::IN_BITS-1:0];
    assign win_ctrl   = '{load: in_accept, advance: r_v1 && rdy2};

    mmas_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (win_ctrl),
        .i_samples (in_samples),
        .o_sums    (sums)
    );

    // ------------------------------------------------------------------
    // Stage 3: floor averages by reciprocal multiply
    // ------------------------------------------------------------------
    logic [CH-1:0][AP_W-1:0] avg_prod;
    logic [CH-1:0][SW-1:0]   r_avg;

    always_comb begin
        for (int ch = 0; ch < CH; ch++) begin
            avg_prod[ch] = AP_W'(sums[ch]) * AP_W'(AVG_M);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            for (int ch = 0; ch < CH; ch++) begin
                r_avg[ch] <= avg_prod[ch][AVG_S +: SW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: multiply the scaled channels by the gain; carry base rail
    // ------------------------------------------------------------------
    logic [SCH-1:0][mmas_pkg::PROD_W-1:0] r_prod;
    logic [SW-1:0]                        r_base4;

    always_ff @(posedge i_clk) begin
        if (r_v3 && rdy4) begin
            for (int ch = 0; ch < SCH; ch++) begin
                r_prod[ch] <= mmas_pkg::PROD_W'(r_avg[ch]) * mmas_pkg::PROD_W'(r_gain);
            end
            r_base4 <= r_avg[CH-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by 1000 and saturate. Products at or above the
    // saturation limit clamp; the rest fit DIV_N bits and divide exactly.
    // ------------------------------------------------------------------
    logic [SCH-1:0][mmas_pkg::QP_W-1:0] quot_prod;
    logic [SCH-1:0][LW-1:0]             n_lvl;
    logic [SCH-1:0][LW-1:0]             r_lvl;
    logic [SW-1:0]                      r_base5;

    always_comb begin
        for (int ch = 0; ch < SCH; ch++) begin
            quot_prod[ch] = mmas_pkg::QP_W'(r_prod[ch][mmas_pkg::DIV_N-1:0])
                          * mmas_pkg::QP_W'(mmas_pkg::MILLI_RECIP);
            if (r_prod[ch] >= mmas_pkg::PROD_W'(mmas_pkg::SAT_LIMIT)) begin
                n_lvl[ch] = mmas_pkg::LEVEL_MAX;
            end else begin
                n_lvl[ch] = quot_prod[ch][mmas_pkg::DIV_SHIFT +: LW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && rdy5) begin
            r_lvl   <= n_lvl;
            r_base5 <= r_base4;
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {(mmas_pkg::OUT_TDATA_W - mmas_pkg::OUT_BITS)'(0), r_base5, r_lvl};

endmodule

`default_nettype wire

// File: design/mmas_checker.sv
// ----------------------------------------------------------------------------
// Moving-average scaler port checker
// Watches the top-level ports for handshake and flow errors.
// ----------------------------------------------------------------------------
`default_nettype none

module mmas_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_cfg_valid,
    input wire                              o_cfg_ready,
    input wire [mmas_pkg::GAIN_W-1:0]       i_cfg_data,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [mmas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int SCALED_BITS = mmas_pkg::SCALED_CH * mmas_pkg::LEVEL_W;

    logic [3:0] r_count;
    logic       r_gain_zero;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Track words in flight and whether the gain is zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_gain_zero <= 1'b0;
        end else begin
            r_count <= r_count + 4'(in_acc) - 4'(out_acc);
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain_zero <= (i_cfg_data == '0);
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_count != 4'd0)
        else $error("output word without an accepted input word");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 4'd0 |-> s_axis_tready)
        else $error("input stalled while pipeline is empty");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain_zero && m_axis_tvalid |-> m_axis_tdata[SCALED_BITS-1:0] == '0)
        else $error("nonzero scaled level with zero gain");

    a_zero_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[mmas_pkg::OUT_TDATA_W-1:mmas_pkg::OUT_BITS] == '0)
        else $error("fill bits of output word not zero");

endmodule

bind multichannel_moving_average_scaler mmas_checker u_mmas_checker (.*);

`default_nettype wire
